// File: sv/gdea_pkg.sv
package gdea_pkg;

	// grid size limits
	localparam int unsigned MaxWidth  = 1024;
	localparam int unsigned MaxHeight = 4096;
	localparam int unsigned MinSize   = 5;

	localparam int unsigned ColW    = $clog2(MaxWidth);
	localparam int unsigned RowW    = $clog2(MaxHeight);
	localparam int unsigned WidthW  = 11;
	localparam int unsigned HeightW = 13;

	// configuration port
	localparam int unsigned CfgDataW  = 13;
	localparam int unsigned CfgIndexW = 3;

	localparam logic [CfgIndexW-1:0] RegFrameWidth  = 3'd0;
	localparam logic [CfgIndexW-1:0] RegFrameHeight = 3'd1;
	localparam logic [CfgIndexW-1:0] RegEmptyId     = 3'd2;
	localparam logic [CfgIndexW-1:0] RegFillId      = 3'd3;
	localparam logic [CfgIndexW-1:0] RegFillWall    = 3'd4;
	localparam logic [CfgIndexW-1:0] RegThreshold   = 3'd5;

	// input op codes
	localparam logic OpCell  = 1'b0;
	localparam logic OpDrain = 1'b1;

	// result queue
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
	localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

	// one grid cell: block id over wall id
	typedef struct packed {
		logic [7:0] block;
		logic [7:0] wall;
	} cell_t;

	// line store entry: older row over newer row
	typedef struct packed {
		cell_t upper;
		cell_t lower;
	} line_t;

	typedef struct packed {
		logic [7:0] block;
		logic [7:0] wall;
		logic       last;
	} result_t;

	// window slots, row-major with the oldest row first
	localparam int unsigned WinCentre = 4;
	localparam int unsigned WinTopNew = 2;
	localparam int unsigned WinMidNew = 5;
	localparam int unsigned WinBotNew = 8;

	// wall pick order: left, right, up, down, then the diagonals
	localparam logic [3:0] WallOrder [8] = '{
		4'd3, 4'd5, 4'd1, 4'd7, 4'd0, 4'd2, 4'd6, 4'd8
	};

endpackage

// File: sv/gdea_ram.sv
module gdea_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/grid_dilate_erode_automaton.sv
// a result is ready once the item that completes its 3x3 window (frame_width+1 items after the
//   centre cell) has passed the stage 1 registers, the window and the result queue
// throughput: one item per cycle unless stalled, set by the single line store memory (read
//   at accept, written back next cycle) and a 4-entry result queue that holds in-flight credit
// reset: counters, flags and queue cleared, registers at their defaults; line store and
//   window are not cleared and need no clearing pass
module grid_dilate_erode_automaton (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gdea_pkg::CfgIndexW-1:0]   cfg_index,
	input  logic [gdea_pkg::CfgDataW-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic [7:0]                       cell_block,
	input  logic [7:0]                       cell_wall,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_block,
	output logic [7:0]                       out_wall,
	output logic                             last_cell
);

	// configuration registers, sizes stored clamped
	logic [gdea_pkg::WidthW-1:0]  w_q;
	logic [gdea_pkg::HeightW-1:0] h_q;
	logic [7:0]                   empty_id_q;
	logic [7:0]                   fill_id_q;
	logic [7:0]                   fill_wall_q;
	logic [3:0]                   thr_q;

	// frame counters
	logic [gdea_pkg::ColW-1:0] column_count_q;
	logic [gdea_pkg::RowW-1:0] row_count_q;
	logic [gdea_pkg::ColW-1:0] ccol_q;
	logic [gdea_pkg::RowW-1:0] crow_q;
	logic                      done_q;

	// pipeline
	logic                      v_s1_q;
	logic                      emit_s1_q;
	logic                      interior_s1_q;
	logic                      last_s1_q;
	logic [gdea_pkg::ColW-1:0] col_s1_q;
	gdea_pkg::cell_t           cell_s1_q;
	logic                      fwd_q;
	gdea_pkg::line_t           fwd_data_q;
	logic                      emit_s2_q;
	logic                      interior_s2_q;
	logic                      last_s2_q;
	gdea_pkg::cell_t           window_q [9];

	// result queue
	gdea_pkg::result_t             fifo_q [gdea_pkg::FifoDepth];
	logic [gdea_pkg::FifoPtrW-1:0] wr_ptr_q;
	logic [gdea_pkg::FifoPtrW-1:0] rd_ptr_q;
	logic [gdea_pkg::FifoCntW-1:0] count_q;

	logic                          acc;
	logic                          acc_shift;
	logic                          acc_emit;
	logic                          acc_last;
	logic                          acc_interior;
	logic                          col_last;
	logic                          cell_emit;
	logic [gdea_pkg::HeightW-1:0]  row_inc;
	logic [gdea_pkg::WidthW-1:0]   ccol_inc;
	logic [gdea_pkg::HeightW-1:0]  crow_inc;
	logic                          ccol_last;
	logic                          size_write;
	gdea_pkg::cell_t               cell_in;
	gdea_pkg::line_t               ram_rdata;
	gdea_pkg::line_t               line_rd;
	gdea_pkg::line_t               line_wr;
	logic [gdea_pkg::FifoCntW:0]   credit;
	logic                          pop;
	logic [gdea_pkg::WidthW-1:0]   cfg_w;
	logic [gdea_pkg::HeightW-1:0]  cfg_h;
	logic [3:0]                    empties;
	logic [7:0]                    new_block;
	logic [7:0]                    new_wall;
	logic [7:0]                    pick_wall;
	logic [8:0]                    is_empty;

	function automatic logic [gdea_pkg::FifoCntW-1:0] FifoCntOne(input logic b);
		return gdea_pkg::FifoCntW'(b);
	endfunction

	// credit check: room in the queue for everything in flight plus this item
	assign credit = {1'b0, count_q} + (gdea_pkg::FifoCntW+1)'(emit_s1_q)
		+ (gdea_pkg::FifoCntW+1)'(emit_s2_q);
	assign in_stall = credit >= (gdea_pkg::FifoCntW+1)'(gdea_pkg::FifoDepth);

	// accept decode
	assign acc       = in_valid && !in_stall;
	assign acc_shift = acc && (done_q || op == gdea_pkg::OpCell);
	assign col_last  = ({1'b0, column_count_q} + 11'd1) == w_q;
	assign cell_emit = (row_count_q >= 12'd2)
		|| (row_count_q == 12'd1 && column_count_q != '0);
	assign acc_emit  = acc_shift && (done_q || cell_emit);
	assign row_inc   = {1'b0, row_count_q} + 13'd1;
	assign cell_in   = done_q ? '0 : {cell_block, cell_wall};

	// centre position of the result this item releases
	assign ccol_inc     = {1'b0, ccol_q} + 11'd1;
	assign crow_inc     = {1'b0, crow_q} + 13'd1;
	assign ccol_last    = ccol_inc == w_q;
	assign acc_last     = ccol_last && (crow_inc == h_q);
	assign acc_interior = (crow_q >= 12'd2) && (({1'b0, crow_q} + 13'd2) < h_q)
		&& (ccol_q >= 10'd2) && (({1'b0, ccol_q} + 11'd2) < w_q);

	// size clamp on write
	always_comb begin
		cfg_w = cfg_data[gdea_pkg::WidthW-1:0];
		if (cfg_w < 11'(gdea_pkg::MinSize)) begin
			cfg_w = 11'(gdea_pkg::MinSize);
		end else if (cfg_w > 11'(gdea_pkg::MaxWidth)) begin
			cfg_w = 11'(gdea_pkg::MaxWidth);
		end
		cfg_h = cfg_data[gdea_pkg::HeightW-1:0];
		if (cfg_h < 13'(gdea_pkg::MinSize)) begin
			cfg_h = 13'(gdea_pkg::MinSize);
		end else if (cfg_h > 13'(gdea_pkg::MaxHeight)) begin
			cfg_h = 13'(gdea_pkg::MaxHeight);
		end
	end

	assign size_write = cfg_we
		&& (cfg_index == gdea_pkg::RegFrameWidth || cfg_index == gdea_pkg::RegFrameHeight);

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= 11'(gdea_pkg::MaxWidth);
			h_q         <= 13'd256;
			empty_id_q  <= 8'd0;
			fill_id_q   <= 8'd1;
			fill_wall_q <= 8'd0;
			thr_q       <= 4'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gdea_pkg::RegFrameWidth:  w_q         <= cfg_w;
				gdea_pkg::RegFrameHeight: h_q         <= cfg_h;
				gdea_pkg::RegEmptyId:     empty_id_q  <= cfg_data[7:0];
				gdea_pkg::RegFillId:      fill_id_q   <= cfg_data[7:0];
				gdea_pkg::RegFillWall:    fill_wall_q <= cfg_data[7:0];
				gdea_pkg::RegThreshold:   thr_q       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// frame counters, restarted by a size write or the last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
			ccol_q         <= '0;
			crow_q         <= '0;
			done_q         <= 1'b0;
		end else if (size_write || (acc_emit && acc_last)) begin
			column_count_q <= '0;
			row_count_q    <= '0;
			ccol_q         <= '0;
			crow_q         <= '0;
			done_q         <= 1'b0;
		end else if (acc_shift) begin
			column_count_q <= col_last ? '0 : column_count_q + 10'd1;
			if (!done_q && col_last) begin
				if (row_inc >= h_q) begin
					row_count_q <= '0;
					done_q      <= 1'b1;
				end else begin
					row_count_q <= row_inc[gdea_pkg::RowW-1:0];
				end
			end
			if (acc_emit) begin
				if (ccol_last) begin
					ccol_q <= '0;
					crow_q <= crow_inc[gdea_pkg::RowW-1:0];
				end else begin
					ccol_q <= ccol_inc[gdea_pkg::ColW-1:0];
				end
			end
		end
	end

	// line store: read at accept, write back from stage 1
	gdea_ram #(
		.Width($bits(gdea_pkg::line_t)),
		.Depth(gdea_pkg::MaxWidth)
	) u_line_ram (
		.clk   (clk),
		.we    (v_s1_q),
		.waddr (col_s1_q),
		.wdata (line_wr),
		.re    (acc_shift),
		.raddr (column_count_q),
		.rdata (ram_rdata)
	);

	// bypass the write that lands on the same column as this read
	assign line_rd = fwd_q ? fwd_data_q : ram_rdata;
	assign line_wr = '{upper: line_rd.lower, lower: cell_s1_q};

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q    <= 1'b0;
			emit_s1_q <= 1'b0;
			fwd_q     <= 1'b0;
			emit_s2_q <= 1'b0;
		end else begin
			v_s1_q    <= acc_shift;
			emit_s1_q <= acc_emit;
			fwd_q     <= v_s1_q && acc_shift && (col_s1_q == column_count_q);
			emit_s2_q <= emit_s1_q;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (acc_shift) begin
			col_s1_q      <= column_count_q;
			cell_s1_q     <= cell_in;
			interior_s1_q <= acc_interior;
			last_s1_q     <= acc_last;
		end
		fwd_data_q    <= line_wr;
		interior_s2_q <= interior_s1_q;
		last_s2_q     <= last_s1_q;
	end

	// window shift, new column on the right
	always_ff @(posedge clk) begin
		if (v_s1_q) begin
			for (int r = 0; r < 3; r++) begin
				window_q[r*3]   <= window_q[r*3+1];
				window_q[r*3+1] <= window_q[r*3+2];
			end
			window_q[gdea_pkg::WinTopNew] <= line_rd.upper;
			window_q[gdea_pkg::WinMidNew] <= line_rd.lower;
			window_q[gdea_pkg::WinBotNew] <= cell_s1_q;
		end
	end

	// stage 2: neighbour count and new centre value
	always_comb begin
		empties   = '0;
		pick_wall = '0;
		for (int i = 0; i < 9; i++) begin
			is_empty[i] = window_q[i].block == empty_id_q;
		end
		for (int i = 0; i < 9; i++) begin
			if (i != gdea_pkg::WinCentre) begin
				empties = empties + 4'(is_empty[i]);
			end
		end
		// last in order is checked first so the earliest match wins
		for (int i = 7; i >= 0; i--) begin
			if (is_empty[gdea_pkg::WallOrder[i]]
				&& window_q[gdea_pkg::WallOrder[i]].wall != '0) begin
				pick_wall = window_q[gdea_pkg::WallOrder[i]].wall;
			end
		end
		new_block = window_q[gdea_pkg::WinCentre].block;
		new_wall  = window_q[gdea_pkg::WinCentre].wall;
		if (interior_s2_q) begin
			if (is_empty[gdea_pkg::WinCentre]) begin
				if ((4'd8 - empties) >= thr_q) begin
					new_block = fill_id_q;
					new_wall  = fill_wall_q;
				end
			end else if (empties >= thr_q) begin
				new_block = empty_id_q;
				new_wall  = pick_wall;
			end
		end
	end

	// result queue
	assign pop       = out_valid && !out_stall;
	assign out_valid = count_q != '0;
	assign out_block = fifo_q[rd_ptr_q].block;
	assign out_wall  = fifo_q[rd_ptr_q].wall;
	assign last_cell = fifo_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (emit_s2_q) begin
			fifo_q[wr_ptr_q] <= '{block: new_block, wall: new_wall, last: last_s2_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (emit_s2_q) begin
				wr_ptr_q <= wr_ptr_q + gdea_pkg::FifoPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gdea_pkg::FifoPtrW'(1);
			end
			count_q <= count_q + FifoCntOne(emit_s2_q) - FifoCntOne(pop);
		end
	end

	// checks
	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_s2_q |-> count_q < gdea_pkg::FifoCntW'(gdea_pkg::FifoDepth))
		else $error("result queue overrun");

	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> v_s1_q)
		else $error("bypass without a line store access");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, column_count_q} < w_q))
		else $error("column counter past row width");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_emit && acc_last) |=> (column_count_q == '0 && ccol_q == '0
			&& crow_q == '0 && !done_q))
		else $error("frame did not restart after its last cell");

	a_ctr_order: assert property (@(posedge clk) disable iff (!arst_n)
		emit_s2_q |-> $past(emit_s1_q))
		else $error("result without a stage 1 item");

endmodule
